// ===== src/lzssp_pkg.sv =====
package lzssp_pkg;

   localparam int GROUP_TOKENS = 8;
   localparam int GROUP_BYTES  = 3 * GROUP_TOKENS;
   localparam int BUF_AW       = $clog2(GROUP_BYTES);
   localparam int FILL_W       = $clog2(GROUP_BYTES + 1);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int TRAILER_ZEROS = 3;

   localparam logic [1:0] ACT_LITERAL = 2'd0;
   localparam logic [1:0] ACT_REF     = 2'd1;
   localparam logic [1:0] ACT_FINISH  = 2'd2;

   localparam logic [7:0] FLAG_TERM   = 8'h80;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  literal_byte;
      logic [15:0] distance;
      logic [8:0]  match_length;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       last_byte;
   } rsp_type;

   typedef enum logic [1:0] {
      TOK_LITERAL = 2'd0,
      TOK_REF     = 2'd1,
      TOK_FINISH  = 2'd2
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   b0;
      logic [7:0]   b1;
      logic [7:0]   b2;
   } tok_type;

   typedef struct packed {
      logic    valid;
      tok_type tok;
   } tok_head_type;

endpackage

// ===== src/lzssp_front.sv =====
module lzssp_front import lzssp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_type      req_data,
   output tok_head_type head,
   input  logic         head_take
);

   tok_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  accept;
   logic                  keep;
   logic                  take;
   tok_type               tok;
   logic [15:0]           dist_m1;
   logic [7:0]            len_m1;

   assign req_full = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   assign dist_m1  = req_data.distance - 16'd1;
   assign len_m1   = 8'(req_data.match_length - 9'd1);

   always_comb begin
      tok  = '{kind: TOK_LITERAL, b0: req_data.literal_byte, b1: dist_m1[7:0],
               b2: len_m1};
      keep = 1'b1;
      case (req_data.action)
         ACT_LITERAL: tok.kind = TOK_LITERAL;
         ACT_REF: begin
            tok.kind = TOK_REF;
            tok.b0   = dist_m1[15:8];
         end
         ACT_FINISH: tok.kind = TOK_FINISH;
         // unused action code: take the request and drop it
         default: keep = 1'b0;
      endcase
   end

   assign take      = head_take && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.tok   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if ((accept && keep) && !take) begin
         count_in = count_ff + 1'b1;
      end else if (!(accept && keep) && take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         queue_ff[wr_ptr_ff] <= tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/lzssp_back.sv =====
module lzssp_back import lzssp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  tok_head_type head,
   output logic         head_take,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_type      rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_REF1 = 6'b000010,
      ST_REF2 = 6'b000100,
      ST_FLAG = 6'b001000,
      ST_DATA = 6'b010000,
      ST_ZERO = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [7:0]         flag_ff, flag_in;
   logic [2:0]         count_ff, count_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [7:0]         buf_ff [GROUP_BYTES];
   logic [7:0]         emit_flag_ff, emit_flag_in;
   logic [BUF_AW-1:0]  idx_ff, idx_in;
   logic [1:0]         zero_ff, zero_in;
   logic               finish_ff, finish_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff, out_data_in;
   logic               buf_we;
   logic [7:0]         buf_wdata;
   logic               out_ready;
   logic [7:0]         flag_lit, flag_ref, flag_fin;
   logic [2:0]         fin_shift;
   logic [BUF_AW-1:0]  idx_next;
   logic               data_end;

   assign out_ready = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign flag_lit  = {1'b0, flag_ff[7:1]};
   assign flag_ref  = {1'b1, flag_ff[7:1]};
   assign fin_shift = 3'(GROUP_TOKENS - 1) - count_ff;
   assign flag_fin  = (flag_lit | FLAG_TERM) >> fin_shift;
   assign idx_next  = idx_ff + 1'b1;
   assign data_end  = (FILL_W'(idx_next) == fill_ff);

   always_comb begin
      state_in     = state_ff;
      flag_in      = flag_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      emit_flag_in = emit_flag_ff;
      idx_in       = idx_ff;
      zero_in      = zero_ff;
      finish_in    = finish_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      buf_we       = 1'b0;
      buf_wdata    = head.tok.b0;
      head_take    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               case (head.tok.kind)
                  TOK_LITERAL: begin
                     buf_we    = 1'b1;
                     fill_in   = fill_ff + 1'b1;
                     head_take = 1'b1;
                     flag_in   = flag_lit;
                     count_in  = count_ff + 1'b1;
                     if (count_ff == 3'(GROUP_TOKENS - 1)) begin
                        emit_flag_in = flag_lit;
                        flag_in      = '0;
                        finish_in    = 1'b0;
                        state_in     = ST_FLAG;
                     end
                  end
                  TOK_REF: begin
                     buf_we   = 1'b1;
                     fill_in  = fill_ff + 1'b1;
                     state_in = ST_REF1;
                  end
                  TOK_FINISH: begin
                     head_take    = 1'b1;
                     emit_flag_in = flag_fin;
                     flag_in      = '0;
                     count_in     = '0;
                     finish_in    = 1'b1;
                     state_in     = ST_FLAG;
                  end
                  default: head_take = 1'b1;
               endcase
            end
         end
         ST_REF1: begin
            buf_we    = 1'b1;
            buf_wdata = head.tok.b1;
            fill_in   = fill_ff + 1'b1;
            state_in  = ST_REF2;
         end
         ST_REF2: begin
            buf_we    = 1'b1;
            buf_wdata = head.tok.b2;
            fill_in   = fill_ff + 1'b1;
            head_take = 1'b1;
            flag_in   = flag_ref;
            count_in  = count_ff + 1'b1;
            state_in  = ST_IDLE;
            if (count_ff == 3'(GROUP_TOKENS - 1)) begin
               emit_flag_in = flag_ref;
               flag_in      = '0;
               finish_in    = 1'b0;
               state_in     = ST_FLAG;
            end
         end
         ST_FLAG: begin
            if (out_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = '{byte_out: emit_flag_ff,
                                last_byte: (fill_ff == '0) && !finish_ff};
               idx_in  = '0;
               zero_in = '0;
               if (fill_ff != '0) begin
                  state_in = ST_DATA;
               end else if (finish_ff) begin
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DATA: begin
            if (out_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = '{byte_out: buf_ff[idx_ff],
                                last_byte: data_end && !finish_ff};
               idx_in = idx_next;
               if (data_end) begin
                  fill_in  = '0;
                  state_in = finish_ff ? ST_ZERO : ST_IDLE;
               end
            end
         end
         ST_ZERO: begin
            if (out_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = '{byte_out: 8'h00,
                                last_byte: zero_ff == 2'(TRAILER_ZEROS - 1)};
               zero_in = zero_ff + 1'b1;
               if (zero_ff == 2'(TRAILER_ZEROS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[fill_ff[BUF_AW-1:0]] <= buf_wdata;
      end
      emit_flag_ff <= emit_flag_in;
      out_data_ff  <= out_data_in;
      idx_ff       <= idx_in;
      zero_ff      <= zero_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         finish_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         finish_ff    <= finish_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== src/lzss_flag_group_token_packer.sv =====
// LZSS flag-group token packer. Push tokens (literal, back-reference) and a
// finish request on the req_ side; pop the packed byte stream on the rsp_
// side, one byte per pop, with last_byte marking the final byte that a request
// produces. A request queue of four tokens sits in front of the packing
// sequencer, so requests keep flowing while output is stalled until the
// queue fills. The sequencer writes one buffered byte per cycle while tokens
// are waiting: one byte for a literal, three for a back-reference. A
// completed group or a finish then emits through the output register at one
// byte per cycle while the receiver pops: the flag byte, then the buffered
// bytes (up to 24), plus three zero bytes for a finish. Token intake halts
// during emission. Unused action codes are taken and dropped.
module lzss_flag_group_token_packer import lzssp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   tok_head_type head;
   logic         head_take;

   lzssp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .head      (head),
      .head_take (head_take)
   );

   lzssp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_take (head_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/lzssp_checker.sv =====
module lzssp_checker import lzssp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // a waiting byte that is not popped stays put
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("stalled response changed");

   // reset leaves an empty queue on both sides
   assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("not empty after reset");

   // the request queue fills only through an accepted request
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push && !req_full && !reset))
      else $error("request queue filled without a request");

endmodule

bind lzss_flag_group_token_packer lzssp_checker u_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import lzssp_pkg::*;

   localparam int         STALL_LIMIT  = 2000;
   localparam int         RANDOM_ITEMS = 312;
   localparam int         REQ_W        = $bits(req_type);
   localparam logic [1:0] ACT_UNUSED   = 2'd3;

   // Expected packed byte stream, built from every accepted request.
   class packed_byte_board;
      rsp_type    expected_bytes[$];
      int         errors;
      logic [7:0] flag_acc;
      logic [2:0] tokens_held;
      logic [7:0] group_bytes[GROUP_BYTES];
      int         bytes_held;

      function new();
         errors = 0;
         flag_acc = '0;
         tokens_held = '0;
         bytes_held = 0;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void stash(logic [7:0] b);
         if (bytes_held < GROUP_BYTES) begin
            group_bytes[bytes_held] = b;
            bytes_held++;
         end
      endfunction

      function void queue_byte(logic [7:0] b);
         rsp_type e;
         e.byte_out = b;
         e.last_byte = 1'b0;
         expected_bytes.push_back(e);
      endfunction

      // Emit the flag byte, then the buffered token bytes, and start a new group.
      function void flush_group(logic [7:0] flag);
         queue_byte(flag);
         for (int i = 0; i < bytes_held; i++)
            queue_byte(group_bytes[i]);
         flag_acc = '0;
         tokens_held = '0;
         bytes_held = 0;
      endfunction

      function void take_request(req_type r);
         int          prior_size;
         logic [15:0] dist_code;
         logic [8:0]  len_code;
         rsp_type     tail;
         prior_size = expected_bytes.size();
         case (r.action)
            ACT_LITERAL: begin
               flag_acc = flag_acc >> 1;
               stash(r.literal_byte);
            end
            ACT_REF: begin
               dist_code = r.distance - 16'd1;
               len_code = r.match_length - 9'd1;
               flag_acc = (flag_acc >> 1) | FLAG_TERM;
               stash(dist_code[15:8]);
               stash(dist_code[7:0]);
               stash(len_code[7:0]);
            end
            ACT_FINISH: begin
               // Terminator bit, then right-align over the tokens held so far.
               flush_group(((flag_acc >> 1) | FLAG_TERM) >> (3'd7 - tokens_held));
               for (int k = 0; k < TRAILER_ZEROS; k++)
                  queue_byte(8'h00);
            end
            default: ;
         endcase
         if (r.action == ACT_LITERAL || r.action == ACT_REF) begin
            tokens_held = tokens_held + 3'd1;
            if (tokens_held == 3'd0)
               flush_group(flag_acc);
         end
         if (expected_bytes.size() > prior_size) begin
            tail = expected_bytes.pop_back();
            tail.last_byte = 1'b1;
            expected_bytes.push_back(tail);
         end
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            if (errors < 40)
               $display("%0t unexpected byte: expected none actual %02h last %0b",
                        $time, got.byte_out, got.last_byte);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.byte_out !== want.byte_out) begin
            if (errors < 40)
               $display("%0t byte_out mismatch: expected %02h actual %02h",
                        $time, want.byte_out, got.byte_out);
            errors++;
         end
         if (got.last_byte !== want.last_byte) begin
            if (errors < 40)
               $display("%0t last_byte mismatch: expected %0b actual %0b",
                        $time, want.last_byte, got.last_byte);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   bit               stim_on = 1'b0;
   packed_byte_board board;

   lzss_flag_group_token_packer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic req_type make_request(logic [1:0] act, logic [7:0] lit,
                                            logic [15:0] dist_val, logic [8:0] len);
      req_type r;
      r.action = act;
      r.literal_byte = lit;
      r.distance = dist_val;
      r.match_length = len;
      return r;
   endfunction

   // Mostly well-formed tokens; now and then out-of-range codes or an unused action.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.literal_byte = 8'($urandom);
      r.distance = 16'($urandom);
      r.match_length = 9'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         r.action = ACT_LITERAL;
      end else if (pick < 88) begin
         r.action = ACT_REF;
         if ($urandom_range(0, 9) != 0) begin
            r.distance = 16'($urandom_range(1, 32768));
            r.match_length = 9'($urandom_range(1, 256));
         end
      end else if (pick < 96) begin
         r.action = ACT_FINISH;
      end else begin
         r.action = ACT_UNUSED;
      end
      return r;
   endfunction

   task automatic push_request(req_type r, bit no_gaps);
      while (!no_gaps && $urandom_range(0, 99) < 29) begin
         req_push <= 1'b0;
         req_data <= REQ_W'({$urandom, $urandom});
         @(posedge clock);
      end
      req_data <= r;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.take_request(r);
   endtask

   initial begin
      req_type r;
      int      sent;
      board = new();
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      stim_on = 1'b1;

      // Finish on an empty group.
      push_request(make_request(ACT_FINISH, 8'h00, 16'd1, 9'd1), 1'b0);
      // One full group of edge-value tokens, including wrapped distances and lengths.
      push_request(make_request(ACT_LITERAL, 8'h00, 16'd0, 9'd0), 1'b0);
      push_request(make_request(ACT_LITERAL, 8'hff, 16'hffff, 9'h1ff), 1'b0);
      push_request(make_request(ACT_REF, 8'h00, 16'd1, 9'd1), 1'b0);
      push_request(make_request(ACT_REF, 8'hff, 16'd32768, 9'd256), 1'b0);
      push_request(make_request(ACT_REF, 8'h00, 16'd0, 9'd0), 1'b0);
      push_request(make_request(ACT_REF, 8'h00, 16'hffff, 9'h1ff), 1'b0);
      push_request(make_request(ACT_REF, 8'h00, 16'd40000, 9'd300), 1'b0);
      push_request(make_request(ACT_LITERAL, 8'h5a, 16'd0, 9'd0), 1'b0);
      // Unused action code: dropped.
      push_request(make_request(ACT_UNUSED, 8'h77, 16'd9, 9'd9), 1'b0);
      // Seven back-references then finish: the longest burst a finish makes.
      for (int i = 0; i < 7; i++)
         push_request(make_request(ACT_REF, 8'h00, 16'd1 << (2 * i), 9'd1 << i), 1'b0);
      push_request(make_request(ACT_FINISH, 8'h00, 16'd0, 9'd0), 1'b0);
      push_request(make_request(ACT_LITERAL, 8'ha5, 16'd0, 9'd0), 1'b0);
      push_request(make_request(ACT_FINISH, 8'h00, 16'd0, 9'd0), 1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = random_request();
         push_request(r, sent >= 150 && sent < 230);
         sent++;
      end
      req_push <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // Receiver: random pops, one long hold to back the block up, one stretch of steady pops.
   initial begin
      int hold_left;
      int rx_cycle;
      hold_left = 0;
      rx_cycle = 0;
      wait (stim_on);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            board.check_byte(rsp_data);
         rx_cycle++;
         if (rx_cycle == 300)
            hold_left = 250;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (rx_cycle >= 1200 && rx_cycle < 1800) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= 29);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      wait (stim_on);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench: errors");
      $finish;
   end

endmodule

// ===== files.f =====
src/lzssp_pkg.sv
src/lzssp_front.sv
src/lzssp_back.sv
src/lzss_flag_group_token_packer.sv
src/lzssp_checker.sv
tb/testbench.sv
